// ===== sv/assert_macros.svh =====
// Assertion macros for the sampled moving median top level.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, clocked on the rising edge and idle during reset.
`define SMM_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define SMM_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/smm_pkg.sv =====
// Package for the sampled moving median: widths, register codes and cell control.
// Depends on nothing; imported by the cell and the top level.
package smm_pkg;

	localparam int SMM_MAX_WINDOW = 32;
	localparam int SAMPLE_W       = 16;
	localparam int TICK_W         = 32;
	localparam int WSIZE_W        = 6;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET  = 6'd5;
	localparam logic [TICK_W-1:0]  PERIOD_RESET = 32'd0;

	// Register codes, taken from the word address.
	typedef enum logic {
		REG_WINDOW_SIZE   = 1'b0,
		REG_SAMPLE_PERIOD = 1'b1
	} smm_reg_t;

	// Control broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic                       clear;
		logic                       shift_en;
		logic                       full;
		logic signed [SAMPLE_W-1:0] sample;
	} smm_ctrl_t;

endpackage

// ===== sv/smm_cell.sv =====
// One cell of the sorted window chain: a sample, its age and a valid flag.
// Depends on smm_pkg; instantiated in a row by the top level.
module smm_cell
	import smm_pkg::*;
#(
	parameter int AW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  smm_ctrl_t                  ctrl,
	input  logic [AW-1:0]              evict_age,
	// Old contents of the cell above.
	input  logic                       up_valid,
	input  logic signed [SAMPLE_W-1:0] up_value,
	input  logic [AW-1:0]              up_age,
	input  logic                       up_le,
	// Chain from the cell below.
	input  logic                       dn_dle,
	input  logic                       dn_rle,
	input  logic                       dn_rem_valid,
	input  logic signed [SAMPLE_W-1:0] dn_rem_value,
	input  logic [AW-1:0]              dn_rem_age,
	// Own contents and chain towards the cell above.
	output logic                       valid,
	output logic signed [SAMPLE_W-1:0] value,
	output logic [AW-1:0]              age,
	output logic                       le,
	output logic                       dle,
	output logic                       rle,
	output logic                       rem_valid,
	output logic signed [SAMPLE_W-1:0] rem_value,
	output logic [AW-1:0]              rem_age
);

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [AW-1:0]              age_q;
	logic                       del;
	logic                       nxt_valid;
	logic signed [SAMPLE_W-1:0] nxt_value;
	logic [AW-1:0]              nxt_age;

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

	// The oldest entry leaves once the window is full.
	assign del = valid_q && ctrl.full && (age_q == evict_age);
	// A kept entry that sorts no higher than the new sample stays below it.
	assign le  = valid_q && !del && (value_q <= ctrl.sample);
	assign dle = dn_dle || del;

	// After the eviction, entries above the gap drop down by one place.
	always_comb begin
		if (dle) begin
			rem_valid = up_valid;
			rem_value = up_value;
			rem_age   = up_age;
			rle       = up_le;
		end else begin
			rem_valid = valid_q;
			rem_value = value_q;
			rem_age   = age_q;
			rle       = le;
		end
	end

	// Keep the remaining entry, take the new sample, or take the entry from below.
	always_comb begin
		if (rle) begin
			nxt_valid = rem_valid;
			nxt_value = rem_value;
			nxt_age   = rem_age + AW'(1);
		end else if (dn_rle) begin
			nxt_valid = 1'b1;
			nxt_value = ctrl.sample;
			nxt_age   = '0;
		end else begin
			nxt_valid = dn_rem_valid;
			nxt_value = dn_rem_value;
			nxt_age   = dn_rem_age + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_en) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

endmodule

// ===== sv/sampled_moving_median.sv =====
// Sampled moving median: a sorted chain of cells inserts a sample and evicts the oldest.
// A result word passes stage one and then the output register once its input is taken.
// Throughput: one word per cycle while out_stall holds nothing back; the cell chain updates
// in the accept cycle and the median is picked from it in stage one, through the output register.
// Reset clears the cell valid flags, fill count, held median and last tick at once;
// a register write restarts the filter in the same way.
module sampled_moving_median
	import smm_pkg::*;
#(
	parameter int MAX_WINDOW = SMM_MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [TICK_W-1:0]          tick_now,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic signed [SAMPLE_W-1:0] median,
	output logic                       accepted,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	`include "assert_macros.svh"

	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int NW = (CW > WSIZE_W) ? CW : WSIZE_W;

	logic [WSIZE_W-1:0]         window_size_q;
	logic [TICK_W-1:0]          sample_period_q;
	logic [TICK_W-1:0]          last_tick_q;
	logic [CW-1:0]              fill_q;
	logic signed [SAMPLE_W-1:0] cur_med_q;
	logic                       s1_valid_q;
	logic                       acc_s1;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_med_q;
	logic                       out_acc_q;

	logic                       cfg_wr;
	smm_reg_t                   cfg_reg;
	logic [NW-1:0]              len_n;
	logic [CW-1:0]              len_w;
	logic [IW-1:0]              evict_age;
	logic                       full;
	logic                       tick_ok;
	logic                       in_acc;
	logic                       s1_adv;
	logic [IW-1:0]              med_idx;
	logic signed [SAMPLE_W-1:0] med_sel;
	smm_ctrl_t                  ctrl;

	logic                       c_valid     [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] c_value     [MAX_WINDOW];
	logic [IW-1:0]              c_age       [MAX_WINDOW];
	logic                       c_le        [MAX_WINDOW];
	logic                       c_dle       [MAX_WINDOW];
	logic                       c_rle       [MAX_WINDOW];
	logic                       c_rem_valid [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] c_rem_value [MAX_WINDOW];
	logic [IW-1:0]              c_rem_age   [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]      valid_vec;

	// Configuration port: always ready, word address selects the register.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_reg = smm_reg_t'(paddr[2]);

	always_comb begin
		case (cfg_reg)
			REG_WINDOW_SIZE:   prdata = 32'(window_size_q);
			REG_SAMPLE_PERIOD: prdata = sample_period_q;
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= WSIZE_RESET;
			sample_period_q <= PERIOD_RESET;
		end else if (cfg_wr) begin
			case (cfg_reg)
				REG_WINDOW_SIZE:   window_size_q   <= pwdata[WSIZE_W-1:0];
				REG_SAMPLE_PERIOD: sample_period_q <= pwdata;
				default:           ;
			endcase
		end
	end

	// Effective window length: capped at the chain length, then made odd.
	always_comb begin
		len_n = NW'(window_size_q);
		if (len_n > NW'(MAX_WINDOW)) begin
			len_n = NW'(MAX_WINDOW);
		end
		if (!len_n[0]) begin
			len_n = (len_n == '0) ? NW'(1) : len_n - NW'(1);
		end
		len_w = CW'(len_n);
	end

	assign evict_age = IW'(len_w - CW'(1));
	assign full      = (fill_q == len_w);
	assign tick_ok   = (tick_now - last_tick_q) > sample_period_q;

	// Handshake: stage one holds a word until the output register can take it.
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	assign ctrl.clear    = cfg_wr;
	assign ctrl.shift_en = in_acc && tick_ok && !cfg_wr;
	assign ctrl.full     = full;
	assign ctrl.sample   = sample;

	// Filter state outside the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			fill_q      <= '0;
		end else if (cfg_wr) begin
			last_tick_q <= '0;
			fill_q      <= '0;
		end else if (ctrl.shift_en) begin
			last_tick_q <= tick_now;
			fill_q      <= full ? fill_q : fill_q + CW'(1);
		end
	end

	// The sorted chain of cells.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic                       up_valid;
		logic signed [SAMPLE_W-1:0] up_value;
		logic [IW-1:0]              up_age;
		logic                       up_le;
		logic                       dn_dle;
		logic                       dn_rle;
		logic                       dn_rem_valid;
		logic signed [SAMPLE_W-1:0] dn_rem_value;
		logic [IW-1:0]              dn_rem_age;

		if (i == MAX_WINDOW - 1) begin : g_top
			assign up_valid = 1'b0;
			assign up_value = '0;
			assign up_age   = '0;
			assign up_le    = 1'b0;
		end else begin : g_mid
			assign up_valid = c_valid[i+1];
			assign up_value = c_value[i+1];
			assign up_age   = c_age[i+1];
			assign up_le    = c_le[i+1];
		end

		if (i == 0) begin : g_bottom
			assign dn_dle       = 1'b0;
			assign dn_rle       = 1'b1;
			assign dn_rem_valid = 1'b0;
			assign dn_rem_value = '0;
			assign dn_rem_age   = '0;
		end else begin : g_above
			assign dn_dle       = c_dle[i-1];
			assign dn_rle       = c_rle[i-1];
			assign dn_rem_valid = c_rem_valid[i-1];
			assign dn_rem_value = c_rem_value[i-1];
			assign dn_rem_age   = c_rem_age[i-1];
		end

		smm_cell #(
			.AW (IW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.evict_age    (evict_age),
			.up_valid     (up_valid),
			.up_value     (up_value),
			.up_age       (up_age),
			.up_le        (up_le),
			.dn_dle       (dn_dle),
			.dn_rle       (dn_rle),
			.dn_rem_valid (dn_rem_valid),
			.dn_rem_value (dn_rem_value),
			.dn_rem_age   (dn_rem_age),
			.valid        (c_valid[i]),
			.value        (c_value[i]),
			.age          (c_age[i]),
			.le           (c_le[i]),
			.dle          (c_dle[i]),
			.rle          (c_rle[i]),
			.rem_valid    (c_rem_valid[i]),
			.rem_value    (c_rem_value[i]),
			.rem_age      (c_rem_age[i])
		);

		assign valid_vec[i] = c_valid[i];
	end

	// The median sits at the middle of the filled part of the chain.
	assign med_idx = IW'(fill_q >> 1);
	assign med_sel = acc_s1 ? c_value[med_idx] : cur_med_q;

	// Stage one and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			cur_med_q   <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				cur_med_q <= '0;
			end else if (s1_adv) begin
				cur_med_q <= med_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_s1 <= tick_ok;
		end
		if (s1_adv) begin
			out_med_q <= med_sel;
			out_acc_q <= acc_s1;
		end
	end

	assign median    = out_med_q;
	assign accepted  = out_acc_q;
	assign out_valid = out_valid_q;

	// Checks on the chain and the fill count.
	`SMM_CHECK(a_fill_in_len, clk, arst_n, fill_q <= len_w, "fill count beyond window length")
	`SMM_CHECK(a_valid_count, clk, arst_n, $countones(valid_vec) == 32'(fill_q), "cell valid flags disagree with fill count")
	`SMM_IMPLIES(a_acc_filled, clk, arst_n, s1_valid_q && acc_s1, fill_q != '0, "accepted word with an empty window")

endmodule
